[rtl/rlkp_pkg.sv]
// rlkp_pkg: shared constants, codes, keyword tables and structs for the
// response line keyword parser; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rlkp_pkg;

  localparam int LINE_BYTES    = 64;
  localparam int PAYLOAD_BYTES = 32;
  localparam int BODY_CAP      = LINE_BYTES - 1;
  localparam int PAY_CAP       = PAYLOAD_BYTES - 1;
  localparam int CNT_W         = $clog2(LINE_BYTES);
  localparam int ADDR_W        = $clog2(BODY_CAP);
  localparam int QR_PRE_LEN    = 3;
  localparam int PREFIX_LEN    = 4;
  localparam int KW_NUM        = 10;
  localparam int KW_EXACT      = 9;
  localparam int KW_QR         = 9;
  localparam int KW_TXT_W      = 8 * 14;

  localparam logic [3:0] ST_UNKNOWN  = 4'd0;
  localparam logic [3:0] ST_INIT_OK  = 4'd1;
  localparam logic [3:0] ST_QR_FOUND = 4'd2;
  localparam logic [3:0] ST_QR_INVAL = 4'd3;
  localparam logic [3:0] ST_PHOTO    = 4'd4;
  localparam logic [3:0] ST_SAVE_OK  = 4'd5;
  localparam logic [3:0] ST_SHUTDOWN = 4'd6;
  localparam logic [3:0] ST_SD_ERR   = 4'd7;
  localparam logic [3:0] ST_CAM_ERR  = 4'd8;
  localparam logic [3:0] ST_STOR_ERR = 4'd9;
  localparam logic [3:0] ST_PARSE    = 4'd10;

  localparam logic [7:0] CH_CR = 8'h0d;
  localparam logic [7:0] CH_LF = 8'h0a;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } body_wr_t;

  typedef struct packed {
    logic [3:0]       status;
    logic [CNT_W-1:0] plen;
  } line_info_t;

  function automatic logic [7:0] rsp_char(input logic [1:0] idx);
    logic [7:0] ch;
    case (idx)
      2'd0:    ch = "R";
      2'd1:    ch = "S";
      2'd2:    ch = "P";
      default: ch = ":";
    endcase
    return ch;
  endfunction

  function automatic logic [3:0] kw_len(input logic [3:0] k);
    logic [3:0] len;
    unique case (k)
      4'd0:    len = 4'd7;
      4'd1:    len = 4'd10;
      4'd2:    len = 4'd11;
      4'd3:    len = 4'd7;
      4'd4:    len = 4'd14;
      4'd5:    len = 4'd6;
      4'd6:    len = 4'd7;
      4'd7:    len = 4'd11;
      4'd8:    len = 4'd9;
      4'd9:    len = 4'd3;
      default: len = 4'd0;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] kw_code(input logic [3:0] k);
    logic [3:0] code;
    unique case (k)
      4'd0:    code = ST_INIT_OK;
      4'd1:    code = ST_QR_INVAL;
      4'd2:    code = ST_PHOTO;
      4'd3:    code = ST_SAVE_OK;
      4'd4:    code = ST_SHUTDOWN;
      4'd5:    code = ST_SD_ERR;
      4'd6:    code = ST_CAM_ERR;
      4'd7:    code = ST_STOR_ERR;
      4'd8:    code = ST_PARSE;
      4'd9:    code = ST_QR_FOUND;
      default: code = ST_UNKNOWN;
    endcase
    return code;
  endfunction

  // text is right aligned: the last character sits in the low byte
  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [3:0] idx);
    logic [KW_TXT_W-1:0] txt;
    int                  sh;
    unique case (k)
      4'd0:    txt = KW_TXT_W'("INIT_OK");
      4'd1:    txt = KW_TXT_W'({"QR_", "INVALID"});
      4'd2:    txt = KW_TXT_W'({"PHOTO_", "READY"});
      4'd3:    txt = KW_TXT_W'("SAVE_OK");
      4'd4:    txt = KW_TXT_W'({"SHUTDOWN_", "READY"});
      4'd5:    txt = KW_TXT_W'("SD_ERR");
      4'd6:    txt = KW_TXT_W'("CAM_ERR");
      4'd7:    txt = KW_TXT_W'({"STORAGE_", "ERR"});
      4'd8:    txt = KW_TXT_W'("ERR:PARSE");
      4'd9:    txt = KW_TXT_W'("QR:");
      default: txt = '0;
    endcase
    sh = 8 * (int'(kw_len(k)) - 1 - int'(idx));
    if (sh < 0) begin
      return 8'd0;
    end
    return txt[sh +: 8];
  endfunction

endpackage

`default_nettype wire

[rtl/rlkp_body_mem.sv]
// rlkp_body_mem: body byte store, one write port and one registered read port
// depends on rlkp_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlkp_body_mem (
  input  wire logic                      clk_i,
  input  wire rlkp_pkg::body_wr_t        wr_i,
  input  wire logic                      rd_en_i,
  input  wire logic [rlkp_pkg::ADDR_W-1:0] rd_addr_i,
  output logic [7:0]                     rd_data_o
);
  import rlkp_pkg::*;

  logic [7:0] mem [BODY_CAP];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

[rtl/rlkp_line_track.sv]
// rlkp_line_track: prefix check, body write control, trailing cr/lf trim and
// running keyword match for the current line; depends on rlkp_pkg
`timescale 1ns / 1ps
`default_nettype none

module rlkp_line_track (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 byte_valid_i,
  input  wire logic [7:0]           byte_i,
  input  wire logic                 clear_i,
  output rlkp_pkg::body_wr_t        wr_o,
  output rlkp_pkg::line_info_t      info_o
);
  import rlkp_pkg::*;

  logic [2:0]       prog_q, prog_d;
  logic             fail_q, fail_d;
  logic             zero_q, zero_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic [KW_NUM-1:0] match_q, match_d;
  logic             body_wr;
  logic [CNT_W-1:0] plen;

  always_comb begin
    prog_d  = prog_q;
    fail_d  = fail_q;
    zero_d  = zero_q;
    count_d = count_q;
    used_d  = used_q;
    match_d = match_q;
    body_wr = 1'b0;
    if (clear_i) begin
      prog_d  = '0;
      fail_d  = 1'b0;
      zero_d  = 1'b0;
      count_d = '0;
      used_d  = '0;
      match_d = '1;
    end else if (byte_valid_i && !zero_q && !fail_q) begin
      if (byte_i == 8'd0) begin
        zero_d = 1'b1;
      end else if (prog_q < 3'(PREFIX_LEN)) begin
        if (byte_i == rsp_char(prog_q[1:0])) begin
          prog_d = prog_q + 3'd1;
        end else begin
          fail_d = 1'b1;
        end
      end else if (count_q < CNT_W'(BODY_CAP)) begin
        body_wr = 1'b1;
        count_d = count_q + CNT_W'(1);
        if (byte_i != CH_CR && byte_i != CH_LF) begin
          used_d = count_q + CNT_W'(1);
        end
        for (int k = 0; k < KW_NUM; k++) begin
          if (count_q < CNT_W'(kw_len(4'(k))) &&
              byte_i != kw_char(4'(k), count_q[3:0])) begin
            match_d[k] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q  <= '0;
      fail_q  <= 1'b0;
      zero_q  <= 1'b0;
      count_q <= '0;
      used_q  <= '0;
      match_q <= '1;
    end else begin
      prog_q  <= prog_d;
      fail_q  <= fail_d;
      zero_q  <= zero_d;
      count_q <= count_d;
      used_q  <= used_d;
      match_q <= match_d;
    end
  end

  assign wr_o.en   = body_wr;
  assign wr_o.addr = count_q[ADDR_W-1:0];
  assign wr_o.data = byte_i;

  always_comb begin
    plen = used_q - CNT_W'(QR_PRE_LEN);
    if (plen > CNT_W'(PAY_CAP)) begin
      plen = CNT_W'(PAY_CAP);
    end
  end

  always_comb begin
    info_o.status = ST_UNKNOWN;
    info_o.plen   = '0;
    if (!fail_q && prog_q == 3'(PREFIX_LEN)) begin
      for (int k = KW_EXACT - 1; k >= 0; k--) begin
        if (match_q[k] && used_q == CNT_W'(kw_len(4'(k)))) begin
          info_o.status = kw_code(4'(k));
        end
      end
      if (info_o.status == ST_UNKNOWN && match_q[KW_QR] &&
          used_q >= CNT_W'(QR_PRE_LEN)) begin
        info_o.status = ST_QR_FOUND;
        info_o.plen   = plen;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/response_line_keyword_parser.sv]
// response_line_keyword_parser: top level with end-of-line sequencer and
// output register; depends on rlkp_pkg, rlkp_line_track, rlkp_body_mem
//
// input stream: s_axis_tdata_i carries a line character, s_axis_tuser_i marks
// end of line (tdata ignored then). characters produce no output; they are
// accepted whenever the sequencer is idle.
// output stream: one transaction per payload byte of a "QR:" line, then one
// final transaction with tlast high that carries the status code.
// the prefix check and keyword match run as each character is stored, so an
// end-of-line transaction without payload yields its final result in the next
// cycle. payload bytes come from the body memory, each one read and then
// loaded into the output register, and no further input is taken until the
// final transaction has been loaded into the output register.
// characters are still accepted while a final result waits in the output
// register; an end-of-line transaction waits until the register is free.
// a receiver stall holds the output register and the sequencer.
// reset clears the line state and the output valid; the body memory needs no
// clearing since only bytes written for the current line are read.
`timescale 1ns / 1ps
`default_nettype none

module response_line_keyword_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] char_byte
  input  wire logic        s_axis_tuser_i,   // [0] mode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [3:0] status, [11:4] payload_byte
  output logic             m_axis_tuser_o,   // [0] payload_valid
  output logic             m_axis_tlast_o
);
  import rlkp_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_LD   = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic [3:0]        status_q, status_d;

  logic              m_valid_q, m_valid_d;
  logic [3:0]        m_status_q, m_status_d;
  logic [7:0]        m_byte_q, m_byte_d;
  logic              m_user_q, m_user_d;
  logic              m_last_q, m_last_d;

  logic              out_free;
  logic              in_acc;
  logic              eol_acc;
  logic              rd_en;
  logic [7:0]        rd_data;
  body_wr_t          wr;
  line_info_t        info;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && (!s_axis_tuser_i || out_free);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign eol_acc         = in_acc && s_axis_tuser_i;

  rlkp_line_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_acc && !s_axis_tuser_i),
    .byte_i       (s_axis_tdata_i),
    .clear_i      (eol_acc),
    .wr_o         (wr),
    .info_o       (info)
  );

  rlkp_body_mem u_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q),
    .rd_data_o (rd_data)
  );

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    left_d     = left_q;
    status_d   = status_q;
    rd_en      = 1'b0;
    m_valid_d  = m_valid_q && !m_axis_tready_i;
    m_status_d = m_status_q;
    m_byte_d   = m_byte_q;
    m_user_d   = m_user_q;
    m_last_d   = m_last_q;
    unique case (state_q)
      S_IDLE: begin
        if (eol_acc) begin
          if (info.plen != '0) begin
            ptr_d    = ADDR_W'(QR_PRE_LEN);
            left_d   = info.plen;
            status_d = info.status;
            state_d  = S_RD;
          end else begin
            m_valid_d  = 1'b1;
            m_status_d = info.status;
            m_byte_d   = 8'd0;
            m_user_d   = 1'b0;
            m_last_d   = 1'b1;
          end
        end
      end
      S_RD: begin
        rd_en   = 1'b1;
        state_d = S_LD;
      end
      S_LD: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_status_d = ST_QR_FOUND;
          m_byte_d   = rd_data;
          m_user_d   = 1'b1;
          m_last_d   = 1'b0;
          ptr_d      = ptr_q + ADDR_W'(1);
          left_d     = left_q - CNT_W'(1);
          state_d    = (left_q == CNT_W'(1)) ? S_FIN : S_RD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          m_valid_d  = 1'b1;
          m_status_d = status_q;
          m_byte_d   = 8'd0;
          m_user_d   = 1'b0;
          m_last_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ptr_q     <= '0;
      left_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      left_q    <= left_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    m_status_q <= m_status_d;
    m_byte_q   <= m_byte_d;
    m_user_q   <= m_user_d;
    m_last_q   <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {4'd0, m_byte_q, m_status_q};
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

`ifndef SYNTHESIS
  a_payload_is_qr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[3:0] == ST_QR_FOUND
      && !m_axis_tlast_o)
    else $error("payload transaction without qr status or with tlast");

  a_final_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tdata_o[11:4] == 8'd0)
    else $error("final transaction carries a payload byte");

  a_ld_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LD |-> $past(state_q) == S_RD || $past(state_q) == S_LD)
    else $error("payload load without a preceding memory read");

  a_left_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD || state_q == S_LD |-> left_q != '0)
    else $error("payload sequencer running with no bytes left");
`endif

endmodule

`default_nettype wire
